/* sv/segmented_stack_set_defines.svh */
// Assertion macros shared by the RTL.
`ifndef SEGMENTED_STACK_SET_DEFINES_SVH
`define SEGMENTED_STACK_SET_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sss_pkg.sv */
package sss_pkg;

	localparam int NUM_STACKS     = 16;
	localparam int STACK_CAPACITY = 4;
	localparam int WORD_W         = 32;
	localparam int IDX_W          = 4;
	localparam int CUR_W          = $clog2(NUM_STACKS);
	localparam int FILL_W         = $clog2(STACK_CAPACITY + 1);
	localparam int ELEM_DEPTH     = NUM_STACKS * STACK_CAPACITY;
	localparam int ELEM_AW        = $clog2(ELEM_DEPTH);

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_POP_AT = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_SET_EMPTY = 3'd2,
		ST_SUB_EMPTY = 3'd3,
		ST_IDX_ABOVE = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_REFILL = 5'b00100,
		S_TOP    = 5'b01000,
		S_ELEM   = 5'b10000
	} state_t;

endpackage

/* sv/segmented_stack_set.sv */
// Segmented stack set: one logical stack split into fixed-size sub-stacks.
// Request channel: drive command, value and index with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with status, top_value
// and top_valid; the receiver cannot hold it off, and a new request may be
// taken in that same cycle.
// After the accepting edge, a push that succeeds finishes in the execute
// state; every other request then checks the top and, if the top is not
// empty, reads the element for it; a pop or pop-at that empties the current
// sub-stack adds a refill state before the top check.
// One request is in flight at a time: no new request is taken while busy.
// These states follow from the two synchronous memories, each with one
// write port and one registered read port: a fill-count read for the named
// sub-stack, a fill-count read after falling back to a lower sub-stack, and
// an element read for the new top.
// Reset empties every sub-stack at once through per-sub-stack occupancy
// flags; memory contents are not cleared and no sweep is needed.
`include "segmented_stack_set_defines.svh"

module segmented_stack_set
	import sss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [WORD_W-1:0] value,
	input  logic [IDX_W-1:0]         index,
	output logic                     done,
	output logic [2:0]               status,
	output logic signed [WORD_W-1:0] top_value,
	output logic                     top_valid
);

	state_t                  state_q;
	logic [CUR_W-1:0]        cur_q;
	logic [FILL_W-1:0]       cur_fill_q;
	logic [NUM_STACKS-1:0]   nonempty_q;
	logic                    done_q;
	cmd_t                    cmd_q;
	logic [WORD_W-1:0]       val_q;
	logic [IDX_W-1:0]        idx_q;
	status_t                 status_q;
	logic [WORD_W-1:0]       top_value_q;
	logic                    top_valid_q;

	logic [CUR_W-1:0]        idx_cut;
	logic                    idx_above;
	logic [CUR_W-1:0]        pop_tgt;
	logic [FILL_W-1:0]       tgt_fill;
	logic [FILL_W-1:0]       tgt_dec;
	logic                    cur_full;
	logic                    cur_last;
	logic                    push_fail;
	logic [CUR_W-1:0]        push_stack;
	logic [FILL_W-1:0]       push_slot;
	logic                    pop_ok;
	logic [NUM_STACKS-1:0]   ne_after;
	logic [CUR_W-1:0]        drop_cur;
	logic [FILL_W-1:0]       cur_fill_m1;
	status_t                 exec_status;
	logic                    above_clear;

	logic                    elem_we;
	logic [ELEM_AW-1:0]      elem_waddr;
	logic [ELEM_AW-1:0]      elem_raddr;
	logic [WORD_W-1:0]       elem_rdata;
	logic                    fill_we;
	logic [CUR_W-1:0]        fill_waddr;
	logic [FILL_W-1:0]       fill_wdata;
	logic [CUR_W-1:0]        fill_raddr;
	logic [FILL_W-1:0]       fill_rdata;

	assign idx_cut    = CUR_W'(idx_q);
	assign idx_above  = 32'(idx_q) > 32'(cur_q);
	assign pop_tgt    = (cmd_q == CMD_POP) ? cur_q : idx_cut;
	assign tgt_fill   = (pop_tgt == cur_q) ? cur_fill_q
		: (nonempty_q[pop_tgt] ? fill_rdata : '0);
	assign tgt_dec    = FILL_W'(tgt_fill - 1'b1);
	assign cur_full   = cur_fill_q == FILL_W'(STACK_CAPACITY);
	assign cur_last   = cur_q == CUR_W'(NUM_STACKS - 1);
	assign push_fail  = cur_full && cur_last;
	assign push_stack = cur_full ? CUR_W'(cur_q + 1'b1) : cur_q;
	assign push_slot  = cur_full ? '0 : cur_fill_q;
	assign pop_ok     = ((cmd_q == CMD_POP) || (cmd_q == CMD_POP_AT && !idx_above))
		&& (tgt_fill != '0);
	assign cur_fill_m1 = FILL_W'(cur_fill_q - 1'b1);

	// Fall back to the highest sub-stack still holding data.
	always_comb begin
		ne_after = nonempty_q;
		ne_after[pop_tgt] = 1'b0;
		drop_cur = '0;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (ne_after[i]) begin
				drop_cur = CUR_W'(i);
			end
		end
	end

	always_comb begin
		above_clear = 1'b1;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (32'(i) > 32'(cur_q) && nonempty_q[i]) begin
				above_clear = 1'b0;
			end
		end
	end

	always_comb begin
		unique case (cmd_q)
			CMD_PUSH: begin
				exec_status = push_fail ? ST_FULL : ST_OK;
			end
			CMD_POP: begin
				if (cur_fill_q == '0) begin
					exec_status = (cur_q == '0) ? ST_SET_EMPTY : ST_SUB_EMPTY;
				end else begin
					exec_status = ST_OK;
				end
			end
			CMD_POP_AT: begin
				if (idx_above) begin
					exec_status = ST_IDX_ABOVE;
				end else if (tgt_fill == '0) begin
					exec_status = ST_SUB_EMPTY;
				end else begin
					exec_status = ST_OK;
				end
			end
			default: begin
				exec_status = ST_OK;
			end
		endcase
	end

	assign elem_we    = (state_q == S_EXEC) && (cmd_q == CMD_PUSH) && !push_fail;
	assign elem_waddr = ELEM_AW'(push_stack) * ELEM_AW'(STACK_CAPACITY)
		+ ELEM_AW'(push_slot);
	assign elem_raddr = ELEM_AW'(cur_q) * ELEM_AW'(STACK_CAPACITY)
		+ ELEM_AW'(cur_fill_m1);

	assign fill_we    = (state_q == S_EXEC)
		&& (((cmd_q == CMD_PUSH) && !push_fail) || pop_ok);
	assign fill_waddr = (cmd_q == CMD_PUSH) ? push_stack : pop_tgt;
	assign fill_wdata = (cmd_q == CMD_PUSH) ? FILL_W'(push_slot + 1'b1) : tgt_dec;
	assign fill_raddr = (state_q == S_IDLE) ? CUR_W'(index) : drop_cur;

	sss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ELEM_DEPTH)
	) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (val_q),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	sss_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_STACKS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			cur_fill_q <= '0;
			nonempty_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_PUSH: begin
							if (push_fail) begin
								state_q <= S_TOP;
							end else begin
								cur_q                  <= push_stack;
								cur_fill_q             <= FILL_W'(push_slot + 1'b1);
								nonempty_q[push_stack] <= 1'b1;
								done_q                 <= 1'b1;
								state_q                <= S_IDLE;
							end
						end
						CMD_POP, CMD_POP_AT: begin
							state_q <= S_TOP;
							if (pop_ok) begin
								nonempty_q[pop_tgt] <= (tgt_dec != '0);
								if (pop_tgt == cur_q) begin
									if (tgt_dec != '0) begin
										cur_fill_q <= tgt_dec;
									end else begin
										cur_q   <= drop_cur;
										state_q <= S_REFILL;
									end
								end
							end
						end
						default: begin
							state_q <= S_TOP;
						end
					endcase
				end
				S_REFILL: begin
					cur_fill_q <= nonempty_q[cur_q] ? fill_rdata : '0;
					state_q    <= S_TOP;
				end
				S_TOP: begin
					if (cur_fill_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ELEM;
					end
				end
				S_ELEM: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd_t'(command);
			val_q <= value;
			idx_q <= index;
		end
		if (state_q == S_EXEC) begin
			status_q <= exec_status;
			if (cmd_q == CMD_PUSH && !push_fail) begin
				top_value_q <= val_q;
				top_valid_q <= 1'b1;
			end
		end
		if (state_q == S_TOP && cur_fill_q == '0) begin
			top_value_q <= '0;
			top_valid_q <= 1'b0;
		end
		if (state_q == S_ELEM) begin
			top_value_q <= elem_rdata;
			top_valid_q <= 1'b1;
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign status    = status_q;
	assign top_value = top_value_q;
	assign top_valid = top_valid_q;

	`SSS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but not busy")
	`SSS_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
	`SSS_ASSERT_NOW(a_above_empty, 1'b1, above_clear, "data above current sub-stack")
	`SSS_ASSERT_NOW(a_empty_top, done && !top_valid, top_value == '0, "empty top not zero")
	`SSS_ASSERT_NOW(a_push_top, done && cmd_q == CMD_PUSH && status == ST_OK,
		top_valid && top_value == val_q, "pushed word not on top")

endmodule

/* sv/sss_ram.sv */
module sss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
